FILE: design/stq_pkg.sv
// Package with shared types and constants of the sorted timer queue.
package stq_pkg;
	localparam int NTimers  = 16;
	localparam int TimeBits = 53;
	localparam int IdW      = 4;
	localparam int CntW     = 5;
	localparam int IncW     = 32;

	typedef enum logic [1:0] {
		OP_SET   = 2'd0,
		OP_UNSET = 2'd1,
		OP_TICK  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_ACK   = 2'd0,
		KIND_FIRED = 2'd1,
		KIND_TICK  = 2'd2
	} kind_t;

	// One classified command handed from the front end to the engine.
	typedef struct packed {
		op_t                 op;
		logic [IdW-1:0]      id;
		logic [TimeBits-1:0] t;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIND,
		ST_REMOVE,
		ST_SCAN,
		ST_INSERT,
		ST_FIRE,
		ST_DONE
	} state_t;
endpackage

FILE: design/stq_front.sv
// Front end: accepts input transactions and queues them as commands.
module stq_front import stq_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          op,
	input  logic [IdW-1:0]      timer_id,
	input  logic [TimeBits-1:0] set_time,
	output logic                cmd_valid,
	input  logic                cmd_ready,
	output cmd_t                cmd
);
	// Two-entry queue between the front end and the engine.
	cmd_t       buf_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = buf_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// Payload storage; the command is classified by its op code here.
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q].op <= op_t'(op);
			buf_q[wr_q].id <= timer_id;
			buf_q[wr_q].t  <= set_time;
		end
	end
endmodule

FILE: design/stq_engine.sv
// Engine: keeps the sorted slot list and executes set, unset and tick commands.
module stq_engine import stq_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [IncW-1:0]     cfg_wdata,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  cmd_t                cmd,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          kind,
	output logic [IdW-1:0]      timer_id_res,
	output logic [TimeBits-1:0] time_value,
	output logic                last
);
	state_t              state_q, state_d;
	logic [IncW-1:0]     inc_q;
	logic [TimeBits-1:0] now_q;
	logic [TimeBits-1:0] dl_q [NTimers];
	logic [NTimers-1:0]  armed_q;
	logic [IdW-1:0]      ord_q [NTimers];
	logic [CntW-1:0]     cnt_q;
	cmd_t                cur_q;
	logic [TimeBits-1:0] next_q;
	logic [CntW-1:0]     pos_q;

	logic                ovalid_q;
	logic [1:0]          okind_q;
	logic [IdW-1:0]      oid_q;
	logic [TimeBits-1:0] otime_q;
	logic                olast_q;

	logic                out_free;
	logic                fire_go;
	logic                done_go;
	logic [IdW-1:0]      head_id;
	logic [IdW-1:0]      pos_id;
	logic [IdW-1:0]      pos_i;
	logic                pos_end;

	// The addressed slot id survives the insertion ripple here.
	logic [IdW-1:0] cmd_id_keep;
	logic [IdW-1:0] keep_q;

	assign out_free     = !ovalid_q || out_ready;
	assign out_valid    = ovalid_q;
	assign kind         = okind_q;
	assign timer_id_res = oid_q;
	assign time_value   = otime_q;
	assign last         = olast_q;
	assign cmd_ready    = (state_q == ST_IDLE);
	assign head_id      = ord_q[0];
	assign pos_i        = pos_q[IdW-1:0];
	assign pos_id       = ord_q[pos_i];
	assign pos_end      = (pos_q >= cnt_q);
	assign cmd_id_keep  = keep_q;

	// A result register load: a firing or the final result of a command.
	assign fire_go = (state_q == ST_FIRE) && out_free && (cnt_q != '0)
		&& (dl_q[head_id] < next_q);
	assign done_go = (state_q == ST_DONE) && out_free;

	// Next state selection for the command sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					if (cmd.op == OP_TICK) state_d = ST_FIRE;
					else if ((cmd.op == OP_SET || cmd.op == OP_UNSET) && armed_q[cmd.id])
						state_d = ST_FIND;
					else if (cmd.op == OP_SET) state_d = ST_SCAN;
					else state_d = ST_DONE;
				end
			end
			ST_FIND:   if (pos_id == cur_q.id) state_d = ST_REMOVE;
			ST_REMOVE: begin
				if (pos_q + 5'd1 >= cnt_q)
					state_d = (cur_q.op == OP_SET) ? ST_SCAN : ST_DONE;
			end
			ST_SCAN:   if (pos_end || dl_q[pos_id] > cur_q.t) state_d = ST_INSERT;
			ST_INSERT: if (pos_end) state_d = ST_DONE;
			ST_FIRE: begin
				if (out_free && (cnt_q == '0 || dl_q[head_id] >= next_q)) state_d = ST_DONE;
			end
			ST_DONE:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Control registers: increment, time, armed flags, list length, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_q    <= IncW'(20480);
			now_q    <= '0;
			armed_q  <= '0;
			cnt_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (cfg_we) inc_q <= cfg_wdata;
			if (fire_go || done_go) ovalid_q <= 1'b1;
			else if (out_ready) ovalid_q <= 1'b0;
			unique case (state_q)
				ST_REMOVE: begin
					if (pos_q + 5'd1 >= cnt_q) begin
						cnt_q <= cnt_q - 5'd1;
						armed_q[cur_q.id] <= 1'b0;
					end
				end
				ST_INSERT: begin
					if (pos_end) begin
						cnt_q <= cnt_q + 5'd1;
						armed_q[cmd_id_keep] <= 1'b1;
					end
				end
				ST_FIRE: begin
					if (fire_go) begin
						cnt_q <= cnt_q - 5'd1;
						armed_q[head_id] <= 1'b0;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						if (cur_q.op == OP_TICK) now_q <= next_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) keep_q <= cmd.id;
	end

	// Datapath: list moves, deadline writes and output payload.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cur_q  <= {cmd.op, cmd.id, (cmd.t < now_q) ? now_q : cmd.t};
				pos_q  <= '0;
				next_q <= now_q + TimeBits'(inc_q);
			end
			ST_FIND: if (pos_id != cur_q.id) pos_q <= pos_q + 5'd1;
			ST_REMOVE: begin
				if (pos_q + 5'd1 >= cnt_q) pos_q <= '0;
				else begin
					ord_q[pos_i] <= ord_q[IdW'(pos_q + 5'd1)];
					pos_q <= pos_q + 5'd1;
				end
			end
			ST_SCAN: if (!(pos_end || dl_q[pos_id] > cur_q.t)) pos_q <= pos_q + 5'd1;
			ST_INSERT: begin
				// Ripple the new id toward the tail, one swap per cycle.
				if (!pos_end) begin
					ord_q[pos_i] <= cur_q.id;
					cur_q.id <= pos_id;
					pos_q <= pos_q + 5'd1;
				end else begin
					ord_q[pos_i] <= cur_q.id;
					dl_q[cmd_id_keep] <= cur_q.t;
				end
			end
			ST_FIRE: begin
				if (fire_go) begin
					okind_q <= KIND_FIRED;
					oid_q   <= head_id;
					otime_q <= dl_q[head_id];
					olast_q <= 1'b0;
					for (int i = 0; i < NTimers - 1; i++) ord_q[i] <= ord_q[i+1];
				end
			end
			ST_DONE: begin
				if (out_free) begin
					olast_q <= 1'b1;
					if (cur_q.op == OP_TICK) begin
						okind_q <= KIND_TICK;
						oid_q   <= '0;
						otime_q <= next_q;
					end else begin
						okind_q <= KIND_ACK;
						oid_q   <= cmd_id_keep;
						otime_q <= now_q;
					end
				end
			end
			default: ;
		endcase
	end

`ifndef ASSERT_OFF
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(NTimers)) else $error("list length above slot count");
	a_cnt_armed: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> $countones(armed_q) == int'(cnt_q))
		else $error("armed flags disagree with list length");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && olast_q && okind_q != KIND_FIRED |-> $past(state_q) == ST_DONE
		|| !$past(out_ready)) else $error("final result outside completion");
`endif
endmodule

FILE: design/sorted_timer_queue.sv
// Top level of the sorted timer queue.
// Input channel: in_valid/in_ready carry op, timer_id and set_time.
// Output channel: out_valid/out_ready carry kind, timer_id_res, time_value, last.
// cfg_we/cfg_wdata write the tick increment (reset 20480); write only when idle.
// A two-entry command queue decouples input from the sequencing engine and
// registers each command before the engine takes it.
// After the engine takes a command: unset of an armed slot finds it and shifts
// later entries over it; set removes an armed slot first, then scans for its place
// and ripples the new id in; a tick fires each due slot, then reports the tick;
// unset of an unarmed slot or op 3 goes straight to its registered final result.
// Reset clears time, armed flags and list length; nothing needs a clearing pass.
// When the receiver stalls, the engine holds its result and waits; the queue
// keeps accepting until two commands are pending.
module sorted_timer_queue import stq_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [IncW-1:0]     cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          op,
	input  logic [IdW-1:0]      timer_id,
	input  logic [TimeBits-1:0] set_time,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          kind,
	output logic [IdW-1:0]      timer_id_res,
	output logic [TimeBits-1:0] time_value,
	output logic                last
);
	cmd_t cmd;
	logic cmd_valid, cmd_ready;

	stq_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .op, .timer_id, .set_time,
		.cmd_valid, .cmd_ready, .cmd
	);

	stq_engine u_engine (
		.clk, .arst_n, .cfg_we, .cfg_wdata, .cmd_valid, .cmd_ready, .cmd,
		.out_valid, .out_ready, .kind, .timer_id_res, .time_value, .last
	);
endmodule
